### src/mmac_pkg.sv
// Shared types and constants of the matrix multiply-accumulate block.
`default_nettype none

package mmac_pkg;

  localparam int unsigned VALUE_W = 32;   // Q16.16 element width
  localparam int unsigned FRAC_W  = 16;   // fraction bits of an element
  localparam int unsigned IDX_IN_W = 4;   // row and column field width
  localparam int unsigned DIM_REG_W = 5;  // dimension register width
  localparam int unsigned CFG_ADDR_W = 2;

  // Operation carried in tuser of each input transfer
  typedef enum logic [2:0] {
    KIND_WR_A  = 3'd0,
    KIND_WR_B  = 3'd1,
    KIND_WR_C  = 3'd2,
    KIND_START = 3'd3,
    KIND_RD_C  = 3'd4
  } kind_e;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 5'd16;

endpackage

`default_nettype wire

### src/mmac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mmac_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/matrix_multiply_accumulate.sv
// Top level of the matrix multiply-accumulate block: C = C + A * B.
`default_nettype none

// Computes C = C + A*B on signed Q16.16 matrices of up to MAX_DIM by MAX_DIM
// entries held in three on-chip RAMs (A, B, C), each addressed row*MAX_DIM+col.
// Each input transfer carries its operation in s_axis_tuser: element writes to
// A, B or C give no result; a read of C passes the RAM read register, then the
// output register, and gives one result with tuser low; a start runs the whole
// multiply and gives one result with tuser high once C is updated. The multiply
// uses a single multiply-accumulate unit fed by one read port per RAM, one
// product per cycle, and the block takes no input until the multiply is done.
// Dimensions above MAX_DIM act as MAX_DIM; a zero dimension leaves C as it is.
// Each C entry is the old value shifted up by 16 plus the exact 64-bit
// products, summed in a wide accumulator, then shifted down by 16 (floor) and
// saturated to 32 bits. Indexes not below MAX_DIM make writes no-ops and reads
// return zero. Memory contents are undefined until written; there is no
// clearing pass. Configuration writes (rows_a, inner_dim, cols_b) are meant to
// happen only while the block is idle.

module matrix_multiply_accumulate
  import mmac_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [DIM_REG_W-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [39:0]           s_axis_tdata,  // row[3:0], col[7:4], value[39:8]
  input  wire logic [2:0]            s_axis_tuser,  // kind[2:0]
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [39:0]                m_axis_tdata,  // row_res[3:0], col_res[7:4],
                                                    // value_res[39:8]
  output logic                       m_axis_tuser   // is_done[0]
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned PROD_W = 2 * VALUE_W;
  localparam int unsigned ACC_W  = PROD_W + IDX_W + 1;
  localparam int unsigned TOP_LO = VALUE_W + FRAC_W - 1;  // top (sign) bit of the result

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // Control that travels with one product through the pipeline
  typedef struct packed {
    logic              valid;
    logic              first;  // first product of a C entry
    logic              last;   // last product of a C entry
    logic [ADDR_W-1:0] caddr;  // C entry being built
  } stage_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_REG_W-1:0] rows_a_q, inner_dim_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_ROWS_A:    rows_a_q    <= cfg_wdata_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_wdata_i;
        CFG_COLS_B:    cols_b_q    <= cfg_wdata_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Clamp each dimension to MAX_DIM
  logic [DIM_W-1:0] n1_eff, n2_eff, n3_eff;
  assign n1_eff = (32'(rows_a_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_a_q);
  assign n2_eff = (32'(inner_dim_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(inner_dim_q);
  assign n3_eff = (32'(cols_b_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_b_q);

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [IDX_IN_W-1:0] in_row, in_col;
  logic [VALUE_W-1:0]  in_value;
  kind_e               in_kind;
  logic                in_inside;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_xfer;
  logic                in_needs_out;

  assign in_row    = s_axis_tdata[3:0];
  assign in_col    = s_axis_tdata[7:4];
  assign in_value  = s_axis_tdata[39:8];
  assign in_kind   = kind_e'(s_axis_tuser);
  assign in_inside = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign in_addr   = ADDR_W'(32'(in_row) * MAX_DIM + 32'(in_col));
  assign in_needs_out = (in_kind == KIND_START) || (in_kind == KIND_RD_C);

  state_e state_q, state_d;
  logic   rd_pend_q;
  logic   out_valid_q;

  // Writes never need the output register; reads and starts wait for it to free up
  assign s_axis_tready = (state_q == ST_IDLE) && !rd_pend_q &&
                         (!out_valid_q || m_axis_tready || !in_needs_out);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Loop counters: k innermost, then j (column of C), then i (row of C)
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] i_q, j_q, k_q;
  logic [DIM_W-1:0] n1_q, n2_q, n3_q;
  logic             k_last, j_last, i_last;
  logic             issue;
  logic             any_zero;

  assign k_last   = (DIM_W'(k_q) + DIM_W'(1)) == n2_q;
  assign j_last   = (DIM_W'(j_q) + DIM_W'(1)) == n3_q;
  assign i_last   = (DIM_W'(i_q) + DIM_W'(1)) == n1_q;
  assign issue    = (state_q == ST_RUN);
  assign any_zero = (n1_eff == '0) || (n2_eff == '0) || (n3_eff == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      n1_q <= '0;
      n2_q <= '0;
      n3_q <= '0;
    end else if (in_xfer && in_kind == KIND_START) begin
      // latch the clamped sizes so the sweep sees one consistent shape
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      n1_q <= n1_eff;
      n2_q <= n2_eff;
      n3_q <= n3_eff;
    end else if (issue) begin
      if (!k_last) begin
        k_q <= k_q + IDX_W'(1);
      end else begin
        k_q <= '0;
        if (!j_last) begin
          j_q <= j_q + IDX_W'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end
      end
    end
  end

  logic [ADDR_W-1:0] a_raddr, b_raddr, iss_caddr;
  assign a_raddr   = ADDR_W'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign b_raddr   = ADDR_W'(32'(k_q) * MAX_DIM + 32'(j_q));
  assign iss_caddr = ADDR_W'(32'(i_q) * MAX_DIM + 32'(j_q));

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] a_rdata, b_rdata, c_rdata;
  logic               c_we;
  logic [ADDR_W-1:0]  c_waddr, c_raddr;
  logic [VALUE_W-1:0] c_wdata;
  logic               wb_valid_q;
  logic [ADDR_W-1:0]  wb_addr_q;
  logic [VALUE_W-1:0] sat_value;

  mmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (in_xfer && in_kind == KIND_WR_A && in_inside),
    .waddr_i (in_addr),
    .wdata_i (in_value),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (in_xfer && in_kind == KIND_WR_B && in_inside),
    .waddr_i (in_addr),
    .wdata_i (in_value),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // C: the sweep writes back finished entries; otherwise the input port owns it.
  // Each entry is read once at its first product and written once after its
  // last, and no other entry touches it, so no forwarding is needed.
  assign c_we    = wb_valid_q || (in_xfer && in_kind == KIND_WR_C && in_inside);
  assign c_waddr = wb_valid_q ? wb_addr_q : in_addr;
  assign c_wdata = wb_valid_q ? sat_value : in_value;
  assign c_raddr = issue ? iss_caddr : in_addr;

  mmac_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // ---------------------------------------------------------------------------
  // MAC pipeline: read -> multiply -> accumulate -> saturate and write back
  // ---------------------------------------------------------------------------
  stage_t rd_stg_q, mul_stg_q;
  stage_t iss_stg;

  assign iss_stg = '{valid: issue, first: (k_q == '0), last: k_last, caddr: iss_caddr};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_stg_q   <= '0;
      mul_stg_q  <= '0;
      wb_valid_q <= 1'b0;
    end else begin
      rd_stg_q   <= iss_stg;
      mul_stg_q  <= rd_stg_q;
      wb_valid_q <= mul_stg_q.valid && mul_stg_q.last;
    end
  end

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic        [VALUE_W-1:0] c_hold_q;
  logic signed [ACC_W-1:0]  acc_q, acc_base, c_ext, p_ext;

  assign prod_d = $signed(a_rdata) * $signed(b_rdata);

  always_ff @(posedge clk_i) begin
    if (rd_stg_q.valid) begin
      prod_q <= prod_d;
      if (rd_stg_q.first) begin
        c_hold_q <= c_rdata;  // old C of the entry starting now
      end
    end
  end

  assign c_ext    = {{(ACC_W-VALUE_W-FRAC_W){c_hold_q[VALUE_W-1]}}, c_hold_q, FRAC_W'(0)};
  assign p_ext    = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_base = mul_stg_q.first ? c_ext : acc_q;

  always_ff @(posedge clk_i) begin
    if (mul_stg_q.valid) begin
      acc_q <= acc_base + p_ext;
    end
    if (mul_stg_q.valid && mul_stg_q.last) begin
      wb_addr_q <= mul_stg_q.caddr;
    end
  end

  // Floor shift by FRAC_W is a bit select; saturate when the upper bits are not
  // all copies of the result's sign
  logic all_ones, all_zeros;
  assign all_ones  = &acc_q[ACC_W-1:TOP_LO];
  assign all_zeros = ~|acc_q[ACC_W-1:TOP_LO];

  always_comb begin
    if (all_ones || all_zeros) begin
      sat_value = acc_q[TOP_LO:FRAC_W];
    end else if (acc_q[ACC_W-1]) begin
      sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
    end
  end

  logic pipe_empty;
  assign pipe_empty = !rd_stg_q.valid && !mul_stg_q.valid && !wb_valid_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_kind == KIND_START) begin
          state_d = any_zero ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_last && j_last && i_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Read-back and output register
  // ---------------------------------------------------------------------------
  logic [IDX_IN_W-1:0] rd_row_q, rd_col_q;
  logic                rd_inside_q;
  logic                load_done;
  logic                is_done_q;
  logic [IDX_IN_W-1:0] row_res_q, col_res_q;
  logic [VALUE_W-1:0]  value_res_q;

  assign load_done = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= in_xfer && in_kind == KIND_RD_C;
      if (rd_pend_q || load_done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_kind == KIND_RD_C) begin
      rd_row_q    <= in_row;
      rd_col_q    <= in_col;
      rd_inside_q <= in_inside;
    end
    if (rd_pend_q) begin
      is_done_q   <= 1'b0;
      row_res_q   <= rd_row_q;
      col_res_q   <= rd_col_q;
      value_res_q <= rd_inside_q ? c_rdata : '0;
    end else if (load_done) begin
      is_done_q   <= 1'b1;
      row_res_q   <= '0;
      col_res_q   <= '0;
      value_res_q <= '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = is_done_q;
  assign m_axis_tdata  = {value_res_q, col_res_q, row_res_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> (state_q == ST_IDLE) && pipe_empty)
    else $error("input transfer while the multiply is busy");

  a_wb_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid_q |-> (state_q == ST_RUN) || (state_q == ST_DRAIN))
    else $error("C write-back outside a multiply");

  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q && !is_done_q)
    else $error("read result lost");

  a_done_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_done |=> out_valid_q && is_done_q && (state_q == ST_IDLE))
    else $error("done result lost");

endmodule

`default_nettype wire

### test/tb.sv
// Testbench of the matrix multiply-accumulate block: stream stimulus and result scoreboard.
`timescale 1ns / 100ps

module tb
  import mmac_pkg::*;
();

  localparam int unsigned DIM = 16;               // MAX_DIM of the instance
  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned SETTLE_CYCLES = 10;     // pipeline drain plus result hand-off
  localparam int unsigned ITEM_BUDGET = 1250;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5; // kinds the block ignores
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic        is_done;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } mac_result_t;

  // Dimension as the block uses it: anything above MAX_DIM counts as MAX_DIM.
  function automatic int unsigned in_use(logic [DIM_REG_W-1:0] d);
    return (32'(d) > DIM) ? DIM : 32'(d);
  endfunction

  // Scoreboard: shadow copy of the three stores and the dimension registers,
  // and the queue of results the block owes.
  class gemm_scoreboard;
    logic [31:0]          a_elem [CELLS];
    logic [31:0]          b_elem [CELLS];
    logic [31:0]          c_elem [CELLS];
    logic [DIM_REG_W-1:0] rows_a;
    logic [DIM_REG_W-1:0] inner_dim;
    logic [DIM_REG_W-1:0] cols_b;
    mac_result_t          expected_results [$];
    int unsigned          errors;

    function new();
      rows_a = DIM_RESET;
      inner_dim = DIM_RESET;
      cols_b = DIM_RESET;
      errors = 0;
      foreach (a_elem[i]) begin
        a_elem[i] = '0;
        b_elem[i] = '0;
        c_elem[i] = '0;
      end
    endfunction

    function void set_dim(cfg_idx_e idx, logic [DIM_REG_W-1:0] v);
      case (idx)
        CFG_ROWS_A:    rows_a = v;
        CFG_INNER_DIM: inner_dim = v;
        CFG_COLS_B:    cols_b = v;
        default: ;
      endcase
    endfunction

    // Floor shift by the fraction width, then clamp to the 32-bit range.
    function logic [31:0] round_down_sat(logic signed [79:0] acc);
      logic signed [79:0] q;
      q = acc >>> FRAC_W;
      if (q > 80'sd2147483647) return 32'h7fff_ffff;
      if (q < -80'sd2147483648) return 32'h8000_0000;
      return q[31:0];
    endfunction

    // C = C + A*B over the entries in use, exact products in a wide sum.
    function void multiply_accumulate();
      int unsigned        n_rows;
      int unsigned        n_inner;
      int unsigned        n_cols;
      logic signed [79:0] acc;
      logic signed [79:0] term;
      longint             prod;
      n_rows = in_use(rows_a);
      n_inner = in_use(inner_dim);
      n_cols = in_use(cols_b);
      for (int i = 0; i < n_rows; i++) begin
        for (int j = 0; j < n_cols; j++) begin
          acc = 80'($signed(c_elem[8'(i * DIM + j)]));
          acc = acc <<< FRAC_W;
          for (int k = 0; k < n_inner; k++) begin
            prod = longint'($signed(a_elem[8'(i * DIM + k)])) *
                   longint'($signed(b_elem[8'(k * DIM + j)]));
            term = 80'(prod);
            acc = acc + term;
          end
          c_elem[8'(i * DIM + j)] = round_down_sat(acc);
        end
      end
    endfunction

    function void note_item(logic [2:0] kind, logic [3:0] row, logic [3:0] col,
                            logic [31:0] value);
      logic [7:0]  idx;
      mac_result_t r;
      idx = {row, col};
      r = '0;
      case (kind)
        KIND_WR_A: a_elem[idx] = value;
        KIND_WR_B: b_elem[idx] = value;
        KIND_WR_C: c_elem[idx] = value;
        KIND_START: begin
          multiply_accumulate();
          r.is_done = 1'b1;
          expected_results.push_back(r);
        end
        KIND_RD_C: begin
          r.row = row;
          r.col = col;
          r.value = c_elem[idx];
          expected_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic is_done, logic [3:0] row, logic [3:0] col,
                               logic [31:0] value);
      mac_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: is_done %0d row %0d col %0d value %h",
               is_done, row, col, value);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (is_done !== want.is_done) begin
        $error("is_done: expected %0d, actual %0d", want.is_done, is_done);
        errors++;
      end
      if (row !== want.row) begin
        $error("row_res: expected %0d, actual %0d", want.row, row);
        errors++;
      end
      if (col !== want.col) begin
        $error("col_res: expected %0d, actual %0d", want.col, col);
        errors++;
      end
      if (value !== want.value) begin
        $error("value_res: expected %h, actual %h", want.value, value);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [DIM_REG_W-1:0]  cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata = '0;   // row[3:0], col[7:4], value[39:8]
  logic [2:0]            s_axis_tuser = '0;   // kind[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;        // row_res[3:0], col_res[7:4], value_res[39:8]
  logic                  m_axis_tuser;        // is_done[0]

  gemm_scoreboard board = new();

  // Entries written so far; nothing unwritten may ever be read by the block.
  bit          a_known [CELLS];
  bit          b_known [CELLS];
  bit          c_known [CELLS];
  int unsigned items_sent = 0;
  int unsigned tx_gap_pct = 0;    // chance per transfer of a gap before it
  int unsigned rx_stall_pct = 0;  // chance per cycle of dropping tready
  bit          long_hold_req = 1'b0;

  matrix_multiply_accumulate #(
    .MAX_DIM(DIM)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap(int unsigned pct);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r >= pct) return 0;
    if (r % 8 == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  // Element values: small Q16.16 numbers, full-range noise and the corners.
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
    if (r < 80) return $urandom();
    case ($urandom_range(4, 0))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'h0001_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Dimensions: mostly tiny so a start stays short, sometimes zero, large or
  // above MAX_DIM.
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return DIM_REG_W'($urandom_range(4, 1));
    if (r < 78) return '0;
    if (r < 90) return DIM_REG_W'($urandom_range(DIM, 5));
    return DIM_REG_W'($urandom_range(31, DIM + 1));
  endfunction

  function automatic logic [2:0] pick_store_kind();
    case ($urandom_range(2, 0))
      0:       return KIND_WR_A;
      1:       return KIND_WR_B;
      default: return KIND_WR_C;
    endcase
  endfunction

  // Offer one input transfer and hold it until the block takes it. Keep
  // tvalid high across back-to-back transfers; drop it only for a gap.
  task automatic send_item(input logic [2:0] kind, input logic [3:0] row,
                           input logic [3:0] col, input logic [31:0] value);
    int unsigned gap;
    gap = pick_gap(tx_gap_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {value, col, row};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(kind, row, col, value);
    if (kind <= KIND_RD_C) items_sent++;
    case (kind)
      KIND_WR_A: a_known[{row, col}] = 1'b1;
      KIND_WR_B: b_known[{row, col}] = 1'b1;
      KIND_WR_C: c_known[{row, col}] = 1'b1;
      default: ;
    endcase
  endtask

  // Read back some C entry that has been written; fall back to entry (0,0),
  // which the directed part always writes.
  task automatic read_known_c();
    logic [7:0] idx;
    idx = 8'($urandom_range(255, 0));
    for (int t = 0; t < 64 && !c_known[idx]; t++) idx = 8'($urandom_range(255, 0));
    if (!c_known[idx]) idx = '0;
    send_item(KIND_RD_C, idx[7:4], idx[3:0], $urandom());
  endtask

  // Stop offering, wait for every owed result, then let the pipeline settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [DIM_REG_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    board.set_dim(idx, v);
    @(posedge clk_i);
  endtask

  // Reprogram all three dimensions, only ever with the block idle.
  task automatic set_dims(input logic [DIM_REG_W-1:0] n_rows,
                          input logic [DIM_REG_W-1:0] n_inner,
                          input logic [DIM_REG_W-1:0] n_cols);
    drain_results();
    write_reg(CFG_ROWS_A, n_rows);
    write_reg(CFG_INNER_DIM, n_inner);
    write_reg(CFG_COLS_B, n_cols);
    cfg_we_i <= 1'b0;
  endtask

  // One well-formed job: load whatever the multiply will touch that is still
  // unwritten, mix in writes, reads, extra starts and ignored kinds, then
  // start and read results back. A crowded job mixes in nothing but reads.
  task automatic run_phase(input bit crowd);
    int unsigned n_rows;
    int unsigned n_inner;
    int unsigned n_cols;
    int unsigned n_ops;
    int unsigned r;
    n_rows = in_use(board.rows_a);
    n_inner = in_use(board.inner_dim);
    n_cols = in_use(board.cols_b);
    for (int i = 0; i < n_rows; i++)
      for (int k = 0; k < n_inner; k++)
        if (!a_known[8'(i * DIM + k)]) send_item(KIND_WR_A, 4'(i), 4'(k), pick_value());
    for (int k = 0; k < n_inner; k++)
      for (int j = 0; j < n_cols; j++)
        if (!b_known[8'(k * DIM + j)]) send_item(KIND_WR_B, 4'(k), 4'(j), pick_value());
    for (int i = 0; i < n_rows; i++)
      for (int j = 0; j < n_cols; j++)
        if (!c_known[8'(i * DIM + j)]) send_item(KIND_WR_C, 4'(i), 4'(j), pick_value());

    n_ops = crowd ? 40 : $urandom_range(20, 3);
    repeat (n_ops) begin
      r = crowd ? 60 : $urandom_range(99, 0);
      if (r < 35) begin
        // small corner, where most jobs keep their operands
        send_item(pick_store_kind(), 4'($urandom_range(3, 0)), 4'($urandom_range(3, 0)),
                  pick_value());
      end else if (r < 50) begin
        send_item(pick_store_kind(), 4'($urandom()), 4'($urandom()), pick_value());
      end else if (r < 78) begin
        read_known_c();
      end else if (r < 92) begin
        send_item(KIND_START, 4'($urandom()), 4'($urandom()), $urandom());
      end else begin
        send_item(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)), 4'($urandom()),
                  4'($urandom()), $urandom());
      end
    end
    send_item(KIND_START, 4'($urandom()), 4'($urandom()), $urandom());
    repeat ($urandom_range(6, 1)) read_known_c();
  endtask

  // Result side: check every transfer, drop tready at random, and honor a
  // request for one long hold-off so the block backs up into its input.
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4],
                           m_axis_tdata[39:8]);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD_CYCLES;
      end else if (hold == 0) begin
        hold = pick_gap(rx_stall_pct);
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on 1x1 matrices: saturation both ways, floor rounding,
    // far corner of the stores, ignored kinds.
    set_dims(5'd1, 5'd1, 5'd1);
    send_item(KIND_WR_A, 4'd0, 4'd0, 32'h7fff_ffff);
    send_item(KIND_WR_B, 4'd0, 4'd0, 32'h7fff_ffff);
    send_item(KIND_WR_C, 4'd0, 4'd0, 32'h7fff_ffff);
    send_item(KIND_START, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_RD_C, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_WR_A, 4'd0, 4'd0, 32'h8000_0000);
    send_item(KIND_WR_C, 4'd0, 4'd0, 32'h8000_0000);
    send_item(KIND_START, 4'hf, 4'hf, 32'hffff_ffff);
    send_item(KIND_RD_C, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_WR_C, 4'hf, 4'hf, 32'h1234_5678);
    send_item(KIND_RD_C, 4'hf, 4'hf, 32'hffff_ffff);
    send_item(KIND_SPARE_FIRST, 4'h3, 4'hc, 32'h5555_aaaa);
    send_item(KIND_SPARE_FIRST + 3'd1, 4'h0, 4'hf, 32'haaaa_5555);
    send_item(KIND_SPARE_LAST, 4'hf, 4'h0, 32'hffff_ffff);
    // 1.0 * -1.0 added to one LSB
    send_item(KIND_WR_A, 4'd0, 4'd0, 32'h0001_0000);
    send_item(KIND_WR_B, 4'd0, 4'd0, 32'hffff_0000);
    send_item(KIND_WR_C, 4'd0, 4'd0, 32'h0000_0001);
    send_item(KIND_START, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_RD_C, 4'd0, 4'd0, 32'h0000_0000);
    // a product of one LSB by minus one LSB rounds down to -1 LSB
    send_item(KIND_WR_A, 4'd0, 4'd0, 32'h0000_0001);
    send_item(KIND_WR_B, 4'd0, 4'd0, 32'hffff_ffff);
    send_item(KIND_WR_C, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_START, 4'd0, 4'd0, 32'h0000_0000);
    send_item(KIND_RD_C, 4'd0, 4'd0, 32'h0000_0000);

    // Random jobs. The first uses every register above MAX_DIM, which also
    // fills all three stores; the third holds off the result side for a long
    // stretch while reads keep coming back to back.
    phase = 0;
    while (items_sent < ITEM_BUDGET) begin
      case ($urandom_range(3, 0))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 10;
        2:       tx_gap_pct = 30;
        default: tx_gap_pct = 60;
      endcase
      case ($urandom_range(3, 0))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 10;
        2:       rx_stall_pct = 30;
        default: rx_stall_pct = 60;
      endcase
      if (phase == 0) set_dims(5'd31, 5'd31, 5'd31);
      else set_dims(pick_dim(), pick_dim(), pick_dim());
      if (phase == 2) begin
        tx_gap_pct = 0;
        long_hold_req = 1'b1;
        run_phase(1'b1);
      end else begin
        run_phase(1'b0);
      end
      phase++;
    end

    drain_results();
    if (board.errors == 0 && board.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
src/mmac_pkg.sv
src/mmac_ram.sv
src/matrix_multiply_accumulate.sv
test/tb.sv
